>>> src/tlfa_pkg.sv
// Shared types and constants of the text layout font addresser.
package tlfa_pkg;

  // Field widths.
  localparam int COORD_W  = 10;
  localparam int ADDR_W   = 24;
  localparam int BYTE_W   = 8;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 2;

  // Request kinds.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TEXT  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_GB_BASE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ASCII_BASE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_Y    = 2'd2;

  // Register reset values.
  localparam logic [COORD_W-1:0] LIMIT_Y_RESET = 10'd320;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_EOS     = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

  // GB2312 code ranges.
  localparam logic [BYTE_W-1:0] LEAD_MIN     = 8'hA1;
  localparam logic [BYTE_W-1:0] ZONE1_END    = 8'hAA;
  localparam logic [BYTE_W-1:0] ZONE16_FIRST = 8'hB0;
  localparam logic [BYTE_W-1:0] ZONE_END     = 8'hF8;
  localparam logic [15:0]       ROW_CHARS    = 16'd94;
  localparam logic [15:0]       ZONE16_INDEX = 16'd1410;

  // Input item.
  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [BYTE_W-1:0]  text_byte;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [COORD_W-1:0] glyph_x;
    logic [COORD_W-1:0] glyph_y;
    logic [ADDR_W-1:0]  font_addr;
    logic               double_width;
  } out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [ADDR_W-1:0]  gb_font_base;
    logic [ADDR_W-1:0]  ascii_font_base;
    logic [COORD_W-1:0] screen_limit_y;
  } cfg_t;

endpackage

>>> src/tlfa_cfg.sv
// Configuration register file with its APB-style access port.
module tlfa_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlfa_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlfa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tlfa_pkg::cfg_t                cfg
);

  localparam int AW = tlfa_pkg::ADDR_W;
  localparam int CW = tlfa_pkg::COORD_W;
  localparam int DW = tlfa_pkg::PDATA_W;

  tlfa_pkg::cfg_t                  cfg_r;
  logic                            wr_en;
  logic [tlfa_pkg::REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tlfa_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes in the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gb_font_base    <= '0;
      cfg_r.ascii_font_base <= '0;
      cfg_r.screen_limit_y  <= tlfa_pkg::LIMIT_Y_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        tlfa_pkg::REG_GB_BASE:    cfg_r.gb_font_base    <= pwdata[AW-1:0];
        tlfa_pkg::REG_ASCII_BASE: cfg_r.ascii_font_base <= pwdata[AW-1:0];
        tlfa_pkg::REG_LIMIT_Y:    cfg_r.screen_limit_y  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read data for the addressed register.
  always_comb begin
    case (reg_idx)
      tlfa_pkg::REG_GB_BASE:    prdata = DW'(cfg_r.gb_font_base);
      tlfa_pkg::REG_ASCII_BASE: prdata = DW'(cfg_r.ascii_font_base);
      tlfa_pkg::REG_LIMIT_Y:    prdata = DW'(cfg_r.screen_limit_y);
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> src/tlfa_addr.sv
// Glyph bitmap address calculation for ASCII and GB2312 characters.
module tlfa_addr #(
  parameter int GLYPH_BYTES = 32
) (
  input  logic [tlfa_pkg::BYTE_W-1:0] lead_byte,
  input  logic [tlfa_pkg::BYTE_W-1:0] cur_byte,
  input  logic                        double_width,
  input  tlfa_pkg::cfg_t              cfg,
  output logic [tlfa_pkg::ADDR_W-1:0] font_addr
);

  localparam int AW = tlfa_pkg::ADDR_W;
  localparam int BW = tlfa_pkg::BYTE_W;
  // One extra bit so that the halved ASCII product keeps a full address.
  localparam int PW = AW + 1;
  localparam logic [AW-1:0] GLYPH_A = AW'(GLYPH_BYTES);
  localparam logic [PW-1:0] GLYPH_P = PW'(GLYPH_BYTES);

  logic [15:0]   row_base;
  logic [15:0]   col_off;
  logic [15:0]   gb_idx;
  logic [AW-1:0] gb_idx_ext;
  logic [AW-1:0] gb_prod;
  logic [PW-1:0] ascii_diff;
  logic [PW-1:0] ascii_prod;

  // GB2312 glyph index; differences wrap as two's complement.
  always_comb begin
    col_off  = {{(16-BW){1'b0}}, cur_byte} - {{(16-BW){1'b0}}, tlfa_pkg::LEAD_MIN};
    row_base = '0;
    gb_idx   = '0;
    if (lead_byte < tlfa_pkg::ZONE1_END) begin
      row_base = 16'(lead_byte - tlfa_pkg::LEAD_MIN) * tlfa_pkg::ROW_CHARS;
      gb_idx   = row_base + col_off;
    end else if (lead_byte >= tlfa_pkg::ZONE16_FIRST && lead_byte < tlfa_pkg::ZONE_END) begin
      row_base = tlfa_pkg::ZONE16_INDEX
               + 16'(lead_byte - tlfa_pkg::ZONE16_FIRST) * tlfa_pkg::ROW_CHARS;
      gb_idx   = row_base + col_off;
    end
  end

  assign gb_idx_ext = {{(AW-16){gb_idx[15]}}, gb_idx};
  assign gb_prod    = gb_idx_ext * GLYPH_A;

  // ASCII glyphs are half size: offset is (ch - space) * GLYPH_BYTES / 2.
  assign ascii_diff = {{(PW-BW){1'b0}}, cur_byte} - {{(PW-BW){1'b0}}, tlfa_pkg::CHAR_SPACE};
  assign ascii_prod = ascii_diff * GLYPH_P;

  assign font_addr = double_width ? (cfg.gb_font_base + gb_prod)
                                  : (cfg.ascii_font_base + ascii_prod[PW-1:1]);

endmodule

>>> src/text_layout_font_addresser.sv
// Top level of the text layout font addresser: cursor state and handshake pipeline.
//
// The block takes one transaction per clock cycle while in_stall is low. An item
// goes through an input register, then the cursor update and the font address
// logic, then a result register. The cursor, line origin and pending GB2312
// lead byte are updated in that single stage, so back-to-back text bytes need no
// bubbles. A start request, a newline, an end-of-string zero and a GB2312 lead
// byte give no result. A GB2312 glyph is reported when its trail byte arrives, at
// the position the cursor took when the lead byte came in. Configuration
// registers sit at byte addresses 0, 4 and 8 and must only be written while the
// block is idle. There is no clearing pass after reset.
module text_layout_font_addresser #(
  parameter int CELL_ALONG  = 16,
  parameter int CELL_ACROSS = 16,
  parameter int GLYPH_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tlfa_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tlfa_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlfa_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlfa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int CW = tlfa_pkg::COORD_W;
  localparam int BW = tlfa_pkg::BYTE_W;
  localparam logic [CW-1:0] STEP_FULL   = CW'(CELL_ALONG);
  localparam logic [CW-1:0] STEP_HALF   = CW'(CELL_ALONG / 2);
  localparam logic [CW-1:0] STEP_ACROSS = CW'(CELL_ACROSS);
  localparam logic [CW:0]   WRAP_STEP   = (CW + 1)'(CELL_ALONG);

  tlfa_pkg::cfg_t  cfg;
  tlfa_pkg::in_t   s1_r;
  logic            s1_valid_r, s1_valid_nxt;
  tlfa_pkg::out_t  out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [CW-1:0]   cursor_line_r, cursor_line_nxt;
  logic [CW-1:0]   cursor_pos_r, cursor_pos_nxt;
  logic [CW-1:0]   line_origin_r, line_origin_nxt;
  logic [BW-1:0]   lead_byte_r, lead_byte_nxt;
  logic            lead_pending_r, lead_pending_nxt;

  logic            is_text, is_trail, is_eos, is_newline, is_lead, wrap;
  logic            has_result, s1_go, out_free, in_accept;
  logic [CW-1:0]   line_eff, pos_eff;
  logic [tlfa_pkg::ADDR_W-1:0] font_addr;
  logic [BW-1:0]   cur_byte;

  // Configuration registers.
  tlfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input register drains when its item needs no result slot
  // or the result register is free.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!has_result || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Classification of the item in the input register.
  assign cur_byte   = s1_r.text_byte;
  assign is_text    = s1_r.req_type == tlfa_pkg::REQ_TEXT;
  assign is_trail   = is_text && lead_pending_r;
  assign is_eos     = is_text && !lead_pending_r && cur_byte == tlfa_pkg::CHAR_EOS;
  assign is_newline = cur_byte == tlfa_pkg::CHAR_NEWLINE;
  assign wrap       = is_text && !lead_pending_r && !is_eos
                    && (({1'b0, cursor_pos_r} + WRAP_STEP > {1'b0, cfg.screen_limit_y})
                        || is_newline);
  assign is_lead    = is_text && !lead_pending_r && cur_byte >= tlfa_pkg::LEAD_MIN;
  assign has_result = is_trail
                    || (is_text && !is_eos && !is_newline && cur_byte < tlfa_pkg::LEAD_MIN);
  assign line_eff   = wrap ? cursor_line_r + STEP_ACROSS : cursor_line_r;
  assign pos_eff    = wrap ? line_origin_r : cursor_pos_r;

  // Font address of the glyph.
  tlfa_addr #(
    .GLYPH_BYTES (GLYPH_BYTES)
  ) u_addr (
    .lead_byte    (lead_byte_r),
    .cur_byte     (cur_byte),
    .double_width (is_trail),
    .cfg          (cfg),
    .font_addr    (font_addr)
  );

  // Cursor and lead byte update.
  always_comb begin
    cursor_line_nxt  = cursor_line_r;
    cursor_pos_nxt   = cursor_pos_r;
    line_origin_nxt  = line_origin_r;
    lead_byte_nxt    = lead_byte_r;
    lead_pending_nxt = lead_pending_r;
    if (s1_go) begin
      if (!is_text) begin
        cursor_line_nxt  = s1_r.start_x;
        cursor_pos_nxt   = s1_r.start_y;
        line_origin_nxt  = s1_r.start_y;
        lead_pending_nxt = 1'b0;
      end else if (is_trail) begin
        cursor_pos_nxt   = cursor_pos_r + STEP_FULL;
        lead_pending_nxt = 1'b0;
      end else if (!is_eos) begin
        cursor_line_nxt = line_eff;
        if (is_newline) begin
          cursor_pos_nxt = pos_eff;
        end else if (is_lead) begin
          cursor_pos_nxt   = pos_eff;
          lead_byte_nxt    = cur_byte;
          lead_pending_nxt = 1'b1;
        end else begin
          cursor_pos_nxt = pos_eff + STEP_HALF;
        end
      end
    end
  end

  // Pipeline register next values.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_free) begin
      out_valid_nxt = s1_go && has_result;
      out_nxt.glyph_x      = line_eff;
      out_nxt.glyph_y      = pos_eff;
      out_nxt.font_addr    = font_addr;
      out_nxt.double_width = is_trail;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      cursor_line_r  <= '0;
      cursor_pos_r   <= '0;
      line_origin_r  <= '0;
      lead_byte_r    <= '0;
      lead_pending_r <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      cursor_line_r  <= cursor_line_nxt;
      cursor_pos_r   <= cursor_pos_nxt;
      line_origin_r  <= line_origin_nxt;
      lead_byte_r    <= lead_byte_nxt;
      lead_pending_r <= lead_pending_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_data;
    end
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // A new result only ever follows a text transaction in the input register.
  a_result_from_text: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_r.req_type == tlfa_pkg::REQ_TEXT))
    else $error("result produced without a text transaction");

  // A start request always drops a pending lead byte.
  a_start_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !is_text) |=> !lead_pending_r)
    else $error("lead byte still pending after start request");

  // A trail byte consumes the lead byte and leaves a double-width result.
  a_trail_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && is_trail) |=> (!lead_pending_r && out_valid_r && out_r.double_width))
    else $error("trail byte did not complete a double-width glyph");
`endif

endmodule

>>> test/tb_text_layout_font_addresser.sv
// Self-checking testbench for the text layout font addresser with a built-in glyph predictor.
`timescale 1ns / 1ps

module tb_text_layout_font_addresser;

  localparam int CELL_ALONG    = 16;
  localparam int CELL_ACROSS   = 16;
  localparam int GLYPH_BYTES   = 32;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 160;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IN_BITS       = $bits(tlfa_pkg::in_t);
  localparam int AW            = tlfa_pkg::ADDR_W;
  localparam int CW            = tlfa_pkg::COORD_W;
  localparam int BW            = tlfa_pkg::BYTE_W;
  localparam int PAW           = tlfa_pkg::PADDR_W;
  localparam int PDW           = tlfa_pkg::PDATA_W;

  // Clock, reset and the block's ports.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tlfa_pkg::in_t        in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tlfa_pkg::out_t       out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PAW-1:0]       paddr = '0;
  logic [PDW-1:0]       pwdata = '0;
  logic [PDW-1:0]       prdata;
  logic                 pready;

  // Predictor copy of the registers and the cursor state.
  logic [AW-1:0]        gb_base = '0;
  logic [AW-1:0]        ascii_base = '0;
  logic [CW-1:0]        wrap_limit = tlfa_pkg::LIMIT_Y_RESET;
  logic [CW-1:0]        pen_line = '0;
  logic [CW-1:0]        pen_pos = '0;
  logic [CW-1:0]        line_start = '0;
  logic [BW-1:0]        lead_code = '0;
  logic                 lead_held = 1'b0;

  // Requests waiting to be sent and glyphs waiting to come out.
  tlfa_pkg::in_t        text_reqs[$];
  tlfa_pkg::out_t       glyph_q[$];
  tlfa_pkg::out_t       want_glyph;

  int                   glyph_errors = 0;
  int                   in_idle_pct = 0;
  int                   out_idle_pct = 0;
  int                   in_hold = 0;
  int                   out_hold = 0;
  int                   cycle_count = 0;

  text_layout_font_addresser #(
    .CELL_ALONG(CELL_ALONG),
    .CELL_ACROSS(CELL_ACROSS),
    .GLYPH_BYTES(GLYPH_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the cursor for one accepted request and queue the glyph it yields, if any.
  task automatic place_glyph(input tlfa_pkg::in_t req);
    logic [31:0]     index;
    logic [31:0]     offset;
    logic [7:0]      ch;
    tlfa_pkg::out_t  glyph;
    ch = req.text_byte;
    if (req.req_type == tlfa_pkg::REQ_START) begin
      pen_line = req.start_x;
      pen_pos = req.start_y;
      line_start = req.start_y;
      lead_held = 1'b0;
    end else if (lead_held) begin
      // Any byte after a lead byte completes the GB2312 code, with no wrap check.
      lead_held = 1'b0;
      if (lead_code < tlfa_pkg::ZONE1_END) begin
        index = (32'(lead_code) - 32'(tlfa_pkg::LEAD_MIN)) * 32'(tlfa_pkg::ROW_CHARS)
              + 32'(ch) - 32'(tlfa_pkg::LEAD_MIN);
      end else if (lead_code >= tlfa_pkg::ZONE16_FIRST && lead_code < tlfa_pkg::ZONE_END) begin
        index = 32'(tlfa_pkg::ZONE16_INDEX)
              + (32'(lead_code) - 32'(tlfa_pkg::ZONE16_FIRST)) * 32'(tlfa_pkg::ROW_CHARS)
              + 32'(ch) - 32'(tlfa_pkg::LEAD_MIN);
      end else begin
        index = '0;
      end
      glyph.glyph_x = pen_line;
      glyph.glyph_y = pen_pos;
      glyph.font_addr = gb_base + AW'(index * GLYPH_BYTES);
      glyph.double_width = 1'b1;
      glyph_q.push_back(glyph);
      pen_pos = pen_pos + CW'(CELL_ALONG);
    end else if (ch != tlfa_pkg::CHAR_EOS) begin
      // Wrap to the line origin when the cell would cross the limit, or on a newline.
      if (32'(pen_pos) + CELL_ALONG > 32'(wrap_limit) || ch == tlfa_pkg::CHAR_NEWLINE) begin
        pen_pos = line_start;
        pen_line = pen_line + CW'(CELL_ACROSS);
      end
      if (ch == tlfa_pkg::CHAR_NEWLINE) begin
        index = '0;
      end else if (ch >= tlfa_pkg::LEAD_MIN) begin
        lead_code = ch;
        lead_held = 1'b1;
      end else begin
        offset = ((32'(ch) - 32'(tlfa_pkg::CHAR_SPACE)) * GLYPH_BYTES) >> 1;
        glyph.glyph_x = pen_line;
        glyph.glyph_y = pen_pos;
        glyph.font_addr = ascii_base + offset[AW-1:0];
        glyph.double_width = 1'b0;
        glyph_q.push_back(glyph);
        pen_pos = pen_pos + CW'(CELL_ALONG / 2);
      end
    end
  endtask

  // Input driver: holds a transaction until it is taken, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        place_glyph(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (in_hold > 0) begin
          in_valid <= 1'b0;
          in_hold = in_hold - 1;
        end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_valid <= 1'b0;
          in_hold = $urandom_range(0, 15);
        end else if (text_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= text_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest predicted glyph.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (glyph_q.size() == 0) begin
          $error("unexpected glyph: x %0d y %0d addr %06h dw %0b", out_data.glyph_x,
                 out_data.glyph_y, out_data.font_addr, out_data.double_width);
          glyph_errors++;
        end else begin
          want_glyph = glyph_q.pop_front();
          if (out_data.glyph_x !== want_glyph.glyph_x) begin
            $error("glyph_x: expected %0d, got %0d", want_glyph.glyph_x, out_data.glyph_x);
            glyph_errors++;
          end
          if (out_data.glyph_y !== want_glyph.glyph_y) begin
            $error("glyph_y: expected %0d, got %0d", want_glyph.glyph_y, out_data.glyph_y);
            glyph_errors++;
          end
          if (out_data.font_addr !== want_glyph.font_addr) begin
            $error("font_addr: expected %06h, got %06h", want_glyph.font_addr,
                   out_data.font_addr);
            glyph_errors++;
          end
          if (out_data.double_width !== want_glyph.double_width) begin
            $error("double_width: expected %0b, got %0b", want_glyph.double_width,
                   out_data.double_width);
            glyph_errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold = out_hold - 1;
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        out_hold = $urandom_range(0, 15);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One register write: setup phase, then access phase until pready.
  task automatic write_reg(input logic [tlfa_pkg::REG_IDX_W-1:0] idx,
                           input logic [PDW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tlfa_pkg::REG_GB_BASE:    gb_base = value[AW-1:0];
      tlfa_pkg::REG_ASCII_BASE: ascii_base = value[AW-1:0];
      tlfa_pkg::REG_LIMIT_Y:    wrap_limit = value[CW-1:0];
      default:                  ;
    endcase
  endtask

  task automatic set_layout(input logic [AW-1:0] gb, input logic [AW-1:0] ascii,
                            input logic [CW-1:0] limit);
    write_reg(tlfa_pkg::REG_GB_BASE, PDW'(gb));
    write_reg(tlfa_pkg::REG_ASCII_BASE, PDW'(ascii));
    write_reg(tlfa_pkg::REG_LIMIT_Y, PDW'(limit));
  endtask

  // Unused fields of every request carry random bits.
  task automatic push_start(input logic [CW-1:0] x, input logic [CW-1:0] y);
    tlfa_pkg::in_t req;
    req = tlfa_pkg::in_t'(IN_BITS'($urandom));
    req.req_type = tlfa_pkg::REQ_START;
    req.start_x = x;
    req.start_y = y;
    text_reqs.push_back(req);
  endtask

  task automatic push_byte(input logic [BW-1:0] ch);
    tlfa_pkg::in_t req;
    req = tlfa_pkg::in_t'(IN_BITS'($urandom));
    req.req_type = tlfa_pkg::REQ_TEXT;
    req.text_byte = ch;
    text_reqs.push_back(req);
  endtask

  // Random strings: mostly printable ASCII and GB2312 pairs, with some noise.
  task automatic queue_random_text(input int count);
    int sent;
    int len;
    int pick;
    logic [CW-1:0] y;
    sent = 0;
    while (sent < count) begin
      if (wrap_limit > 16 && $urandom_range(0, 1) == 1) begin
        y = CW'($urandom_range(0, wrap_limit - 16));
      end else begin
        y = CW'($urandom_range(0, 1023));
      end
      push_start(CW'($urandom_range(0, 1023)), y);
      sent++;
      len = $urandom_range(1, 40);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          push_byte(BW'($urandom_range(32'h20, 32'h7E)));
          sent++;
        end else if (pick < 80) begin
          push_byte(BW'($urandom_range(32'hA1, 32'hF7)));
          push_byte(BW'($urandom_range(32'hA1, 32'hFE)));
          sent += 2;
        end else if (pick < 86) begin
          push_byte(tlfa_pkg::CHAR_NEWLINE);
          sent++;
        end else if (pick < 96) begin
          push_byte(BW'($urandom_range(0, 255)));
          sent++;
        end else begin
          // Leave a lead byte dangling for the next start to drop, unless a following end-of-string zero completes it.
          push_byte(BW'($urandom_range(32'hA1, 32'hFF)));
          sent++;
          break;
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        push_byte(tlfa_pkg::CHAR_EOS);
        sent++;
      end
    end
  endtask

  // Wait until every request is sent and every glyph has come out.
  task automatic settle();
    while (text_reqs.size() != 0 || in_valid || glyph_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings under the reset settings.
    in_idle_pct = 10;
    out_idle_pct = 15;
    push_start('0, '0);
    push_byte(8'h41);
    push_byte(tlfa_pkg::CHAR_SPACE);
    push_byte(8'h7F);
    push_byte(8'h01);
    push_byte(8'hA0);
    push_byte(tlfa_pkg::CHAR_EOS);
    push_byte(tlfa_pkg::CHAR_NEWLINE);
    // GB2312 pairs across the zones, the gap zone and the top leads.
    push_byte(tlfa_pkg::ZONE16_FIRST);
    push_byte(tlfa_pkg::LEAD_MIN);
    push_byte(tlfa_pkg::LEAD_MIN);
    push_byte(8'hFE);
    push_byte(8'hA9);
    push_byte(tlfa_pkg::LEAD_MIN);
    push_byte(tlfa_pkg::ZONE1_END);
    push_byte(tlfa_pkg::LEAD_MIN);
    push_byte(8'hF7);
    push_byte(8'hFE);
    push_byte(8'hFF);
    push_byte(tlfa_pkg::CHAR_NEWLINE);
    push_byte(8'hA5);
    push_byte(tlfa_pkg::CHAR_EOS);
    // Dangling lead dropped by a start near the coordinate limits.
    push_byte(8'hC0);
    push_start(10'd1023, 10'd1015);
    push_byte(tlfa_pkg::LEAD_MIN);
    push_byte(tlfa_pkg::LEAD_MIN);
    queue_random_text(PHASE_ITEMS);
    settle();

    set_layout(24'hFFFFFF, 24'hFFFFFF, 10'd1023);
    in_idle_pct = 20;
    out_idle_pct = 0;
    queue_random_text(PHASE_ITEMS);
    settle();

    set_layout('0, '0, '0);
    in_idle_pct = 0;
    out_idle_pct = 25;
    queue_random_text(PHASE_ITEMS);
    settle();

    set_layout(AW'($urandom), AW'($urandom), 10'd16);
    in_idle_pct = 30;
    out_idle_pct = 10;
    queue_random_text(PHASE_ITEMS);
    settle();

    set_layout(AW'($urandom), AW'($urandom), CW'($urandom_range(100, 1023)));
    in_idle_pct = 5;
    out_idle_pct = 40;
    queue_random_text(PHASE_ITEMS);
    settle();

    // Final stretch at full rate on both sides.
    set_layout(AW'($urandom), AW'($urandom), tlfa_pkg::LIMIT_Y_RESET);
    in_idle_pct = 0;
    out_idle_pct = 0;
    queue_random_text(PHASE_ITEMS);
    settle();

    if (glyph_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
